// File: src/json_string_unescape_unit_macros.svh
// ----------------------------------------------------------------------------
// JSON string unescape unit - assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset
`define JSU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition implies another in the next cycle
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define JSU_ASSERT(label, clk, rst_n, prop)
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared by the JSON string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX  = 3'd3
    } scan_mode_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } result_kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_CONTROL     = 3'd1,
        ERR_BAD_ESCAPE  = 3'd2,
        ERR_BAD_HEX     = 3'd3,
        ERR_EOF_ESCAPE  = 3'd4,
        ERR_EOF_UNICODE = 3'd5,
        ERR_EOF_STRING  = 3'd6
    } error_code_t;

    // Work handed from the classifier to the expander
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_ERROR = 2'd2,
        CMD_UTF8  = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [15:0] value;
        error_code_t err;
    } cmd_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Channel payloads
    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_start;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0]   out_byte;
        result_kind_t result_kind;
        error_code_t  error_code;
        logic         last_of_run;
    } out_item_t;

    // Characters
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // UTF-8 limits and marks
    localparam logic [15:0] CP_MAX_1 = 16'h007F;
    localparam logic [15:0] CP_MAX_2 = 16'h07FF;
    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;

endpackage

// File: src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw string bytes, tracks escape state and queues one command per
// item that yields results.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  in_item_t byte_item,
    input  q_stat_t  q_stat,
    output logic     push,
    output cmd_t     cmd
);

    scan_mode_t  mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;

    scan_mode_t  eff_mode;
    logic [1:0]  eff_cnt;
    logic [15:0] eff_acc;
    logic [4:0]  hex;
    logic [15:0] acc_new;
    logic        accept;
    logic [7:0]  c;

    // Decode one hex digit: {ok, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, 4'(ch - 8'h30)};
        end
        else if (ch >= 8'h61 && ch <= 8'h66) begin
            r = {1'b1, 4'(ch - 8'h57)};
        end
        else if (ch >= 8'h41 && ch <= 8'h46) begin
            r = {1'b1, 4'(ch - 8'h37)};
        end
        return r;
    endfunction

    // Hold scanner state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= 2'd0;
            acc_reg  <= 16'd0;
        end
        else begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

    // Classify the item and pick the next state
    always_comb begin
        c          = byte_item.data_byte;
        byte_ready = !q_stat.full;
        accept     = byte_valid && byte_ready;
        eff_mode   = byte_item.string_start ? MODE_STR : mode_reg;
        eff_cnt    = byte_item.string_start ? 2'd0 : cnt_reg;
        eff_acc    = byte_item.string_start ? 16'd0 : acc_reg;
        hex        = hex_decode(c);
        acc_new    = {eff_acc[11:0], hex[3:0]};
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        push       = 1'b0;
        cmd.op     = CMD_BYTE;
        cmd.value  = {8'd0, c};
        cmd.err    = ERR_NONE;

        if (accept) begin
            mode_next = eff_mode;
            cnt_next  = eff_cnt;
            acc_next  = eff_acc;
            unique case (eff_mode)
                MODE_STR: begin
                    push = 1'b1;
                    if (byte_item.end_of_input) begin
                        cmd.op  = CMD_ERROR;
                        cmd.err = ERR_EOF_STRING;
                    end
                    else if (c == CH_QUOTE) begin
                        mode_next = MODE_IDLE;
                        cmd.op    = CMD_CLOSE;
                    end
                    else if (c < CH_SPACE) begin
                        cmd.op  = CMD_ERROR;
                        cmd.err = ERR_CONTROL;
                    end
                    else if (c == CH_BACKSLASH) begin
                        mode_next = MODE_ESC;
                        push      = 1'b0;
                    end
                end
                MODE_ESC: begin
                    push      = 1'b1;
                    mode_next = MODE_STR;
                    if (byte_item.end_of_input) begin
                        cmd.op  = CMD_ERROR;
                        cmd.err = ERR_EOF_ESCAPE;
                    end
                    else begin
                        unique case (c)
                            CH_QUOTE, CH_BACKSLASH, CH_SLASH: cmd.value = {8'd0, c};
                            CH_B: cmd.value = 16'h0008;
                            CH_F: cmd.value = 16'h000C;
                            CH_N: cmd.value = 16'h000A;
                            CH_R: cmd.value = 16'h000D;
                            CH_T: cmd.value = 16'h0009;
                            CH_U: begin
                                mode_next = MODE_HEX;
                                cnt_next  = 2'd0;
                                acc_next  = 16'd0;
                                push      = 1'b0;
                            end
                            default: begin
                                cmd.op  = CMD_ERROR;
                                cmd.err = ERR_BAD_ESCAPE;
                            end
                        endcase
                    end
                end
                MODE_HEX: begin
                    if (byte_item.end_of_input) begin
                        push    = 1'b1;
                        cmd.op  = CMD_ERROR;
                        cmd.err = ERR_EOF_UNICODE;
                    end
                    else if (!hex[4]) begin
                        push    = 1'b1;
                        cmd.op  = CMD_ERROR;
                        cmd.err = ERR_BAD_HEX;
                    end
                    else if (eff_cnt == 2'd3) begin
                        push      = 1'b1;
                        cmd.op    = CMD_UTF8;
                        cmd.value = acc_new;
                        mode_next = MODE_STR;
                        cnt_next  = 2'd0;
                        acc_next  = 16'd0;
                    end
                    else begin
                        cnt_next = eff_cnt + 2'd1;
                        acc_next = acc_new;
                    end
                end
                default: begin
                end
            endcase

            // Drop back to idle on any error
            if (push && cmd.op == CMD_ERROR) begin
                mode_next = MODE_IDLE;
                cnt_next  = 2'd0;
                acc_next  = 16'd0;
            end
        end
    end

endmodule

// File: src/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small command FIFO between classifier and expander. DEPTH is a power of
// two, at least 2.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head_cmd,
    output q_stat_t q_stat
);

    localparam int AW = $clog2(DEPTH);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(push);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
        q_stat.full  = (count_reg == (AW+1)'(DEPTH));
        q_stat.empty = (count_reg == '0);
        head_cmd     = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store an item
    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Expands queued commands into result items through an output register,
// one per cycle while that register is free to take one.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_stat_t   q_stat,
    input  cmd_t      head_cmd,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result_item
);

    logic       cur_valid_reg, cur_valid_next;
    cmd_t       cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;

    logic [1:0]  num;
    logic        last;
    logic        out_free;
    logic        emit;
    logic [7:0]  ubyte;
    logic [15:0] cp;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk) begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // Count the results of the current command and pick the current byte
    always_comb begin
        cp = cur_reg.value;
        if (cur_reg.op != CMD_UTF8 || cp <= CP_MAX_1) begin
            num = 2'd1;
        end
        else if (cp <= CP_MAX_2) begin
            num = 2'd2;
        end
        else begin
            num = 2'd3;
        end
        last = (idx_reg == num - 2'd1);

        ubyte = cp[7:0];
        if (num == 2'd2) begin
            ubyte = (idx_reg == 2'd0) ? (UTF_LEAD2 | {3'd0, cp[10:6]})
                                      : (UTF_CONT | {2'd0, cp[5:0]});
        end
        else if (num == 2'd3) begin
            case (idx_reg)
                2'd0:    ubyte = UTF_LEAD3 | {4'd0, cp[15:12]};
                2'd1:    ubyte = UTF_CONT | {2'd0, cp[11:6]};
                default: ubyte = UTF_CONT | {2'd0, cp[5:0]};
            endcase
        end
    end

    // Emit, advance and refill
    always_comb begin
        out_free = !out_valid_reg || result_ready;
        emit     = cur_valid_reg && out_free;
        pop      = (!cur_valid_reg || (emit && last)) && !q_stat.empty;

        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            cur_next       = head_cmd;
            idx_next       = 2'd0;
        end
        else if (emit && last) begin
            cur_valid_next = 1'b0;
            idx_next       = 2'd0;
        end
        else if (emit) begin
            idx_next = idx_reg + 2'd1;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit) begin
            out_valid_next       = 1'b1;
            out_next.last_of_run = last;
            out_next.error_code  = ERR_NONE;
            out_next.out_byte    = 8'd0;
            case (cur_reg.op)
                CMD_CLOSE: out_next.result_kind = KIND_CLOSE;
                CMD_ERROR: begin
                    out_next.result_kind = KIND_ERROR;
                    out_next.error_code  = cur_reg.err;
                end
                default: begin
                    out_next.result_kind = KIND_BYTE;
                    out_next.out_byte    = ubyte;
                end
            endcase
        end
        else if (result_ready) begin
            out_valid_next = 1'b0;
        end

        result_valid = out_valid_reg;
        result_item  = out_reg;
    end

endmodule

// File: src/json_string_unescape_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// Unescapes JSON string bodies byte by byte into decoded bytes and UTF-8.
// ----------------------------------------------------------------------------
//  channel  | signals                             | payload
//  ---------+-------------------------------------+---------------------------
//  input    | byte_valid / byte_ready / byte_item | data_byte, start, eoi
//  output   | result_valid / result_ready         | out_byte, kind, error, last
//
//  One raw byte is taken per cycle while the command queue has room.
//  A \u escape yields up to 3 output items, one per cycle from the expander
//  while the result side takes them; its six input bytes cover that, so input
//  stalls only when the result side holds off long enough for the queue to fill.
//  The first result item passes through the queue, the current-command register
//  and the output register before it is presented.
//  Reset clears the scanner to idle and empties the queue.
//  Either side may stall; the queue of QUEUE_DEPTH commands decouples them.
// ----------------------------------------------------------------------------
`include "json_string_unescape_unit_macros.svh"

module json_string_unescape_unit
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_item_t  byte_item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result_item
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    cmd_t    head_cmd;

    // Classify incoming bytes
    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Buffer commands
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // Expand commands into result items
    jsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    // Never write a full queue or read an empty one
    `JSU_ASSERT(a_no_overflow, clk, rst_n, !(push && q_stat.full))
    `JSU_ASSERT(a_no_underflow, clk, rst_n, !(pop && q_stat.empty))
    // Close and error items always end their run
    `JSU_ASSERT(a_final_last, clk, rst_n, !result_valid || result_item.result_kind == KIND_BYTE || result_item.last_of_run)
    // Error code only accompanies an error item
    `JSU_ASSERT(a_code_kind, clk, rst_n, !result_valid || result_item.error_code == ERR_NONE || result_item.result_kind == KIND_ERROR)

endmodule
